>>> hdl/plac_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// plac_pkg
// Shared constants, light table entry layout and controller interface types
// for the point light accumulator.
// ============================================================================
package plac_pkg;

    localparam int LIGHT_COUNT_DEF = 32;

    localparam int COORD_W  = 16;
    localparam int SLOT_W   = 5;
    localparam int RADIUS_W = 12;
    localparam int TIME_W   = 32;
    localparam int LEVEL_W  = 8;

    localparam int DIFF_W = COORD_W + 1;
    localparam int PROD_W = 2 * COORD_W;
    localparam int DIST_W = PROD_W + 2;
    localparam int ROOT_W = 2 * RADIUS_W;

    localparam logic [LEVEL_W-1:0] LEVEL_FULL  = 8'd255;
    localparam logic [LEVEL_W-1:0] LEVEL_VIEW  = 8'd32;
    localparam logic [LEVEL_W-1:0] SHADE_MIN   = 8'd32;
    localparam logic [LEVEL_W-1:0] AMBIENT_MAX = 8'd64;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic [1:0] SEL_X = 2'd0;
    localparam logic [1:0] SEL_Y = 2'd1;
    localparam logic [1:0] SEL_Z = 2'd2;
    localparam logic [1:0] SEL_R = 2'd3;

    localparam logic [ROOT_W-1:0] ROOT_BIT_INIT = ROOT_W'(1) << (ROOT_W - 2);

    typedef struct packed {
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic signed [COORD_W-1:0]  z;
        logic        [RADIUS_W-1:0] reach;
        logic        [TIME_W-1:0]   expiry;
    } light_entry_t;

    typedef struct packed {
        logic       wr_en;
        logic       capture;
        logic       idx_clr;
        logic       idx_inc;
        logic       prod_load;
        logic [1:0] mul_sel;
        logic       d2_clr;
        logic       d2_add;
        logic       sq_start;
        logic       sq_step;
        logic       acc_add;
        logic       out_load;
    } plac_cmd_t;

    typedef struct packed {
        logic in_query;
        logic in_full;
        logic hit;
        logic sq_last;
        logic idx_last;
        logic out_free;
    } plac_sts_t;

endpackage

>>> hdl/plac_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// plac_ram
// Generic single write port, single read port RAM with registered read data.
// ============================================================================
module plac_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/plac_datapath.sv
`timescale 1ns / 1ps
// ============================================================================
// plac_datapath
// Light table, shared squaring multiplier, distance compare, bit-serial
// square root, level accumulator and output register.
// ============================================================================
module plac_datapath
    import plac_pkg::*;
#(
    parameter int LIGHT_COUNT = LIGHT_COUNT_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  plac_cmd_t                  cmd,
    output plac_sts_t                  sts,
    input  logic                       s_req_type,
    input  logic [SLOT_W-1:0]          s_light_slot,
    input  logic signed [COORD_W-1:0]  s_coord_x,
    input  logic signed [COORD_W-1:0]  s_coord_y,
    input  logic signed [COORD_W-1:0]  s_coord_z,
    input  logic [RADIUS_W-1:0]        s_light_radius,
    input  logic [TIME_W-1:0]          s_expire_time,
    input  logic [TIME_W-1:0]          s_now_time,
    input  logic [LEVEL_W-1:0]         s_base_light,
    input  logic                       s_full_bright,
    input  logic                       s_view_model,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [LEVEL_W-1:0]         m_ambient_level,
    output logic [LEVEL_W-1:0]         m_shade_level
);

    localparam int IDX_W   = (LIGHT_COUNT > 1) ? $clog2(LIGHT_COUNT) : 1;
    localparam int ACC_W   = 13 + $clog2(LIGHT_COUNT + 1);
    localparam int ENTRY_W = $bits(light_entry_t);

    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic [LIGHT_COUNT-1:0]   valid_reg, valid_next;
    logic                     ent_valid_reg;
    logic signed [COORD_W-1:0] qx_reg, qy_reg, qz_reg;
    logic [TIME_W-1:0]        now_reg;
    logic                     fb_reg;
    logic [ACC_W-1:0]         acc_reg, acc_next;
    logic [PROD_W-1:0]        prod_reg;
    logic [DIST_W-1:0]        d2_reg, d2_next;
    logic [ROOT_W-1:0]        rem_reg, rem_next;
    logic [ROOT_W-1:0]        res_reg, res_next;
    logic [ROOT_W-1:0]        bit_reg, bit_next;
    logic                     m_valid_reg, m_valid_next;
    logic [LEVEL_W-1:0]       amb_reg, shade_reg;

    logic [8:0]               slot_ext;
    logic [IDX_W-1:0]         waddr;
    logic                     in_range;
    logic                     ram_we;
    light_entry_t             wr_entry;
    logic [ENTRY_W-1:0]       rdata;
    light_entry_t             ent;
    logic signed [DIFF_W-1:0] sq_in;
    logic signed [2*DIFF_W-1:0] sq_full;
    logic [ROOT_W:0]          trial;
    logic [ACC_W-1:0]         acc_init;
    logic [LEVEL_W-1:0]       amb_calc, shade_calc;

    assign slot_ext = {4'b0, s_light_slot};
    assign waddr    = slot_ext[IDX_W-1:0];
    assign in_range = slot_ext < 9'(LIGHT_COUNT);
    assign ram_we   = cmd.wr_en && in_range;

    assign wr_entry = '{x: s_coord_x, y: s_coord_y, z: s_coord_z,
                        reach: s_light_radius, expiry: s_expire_time};

    plac_ram #(
        .DATA_W (ENTRY_W),
        .DEPTH  (LIGHT_COUNT),
        .ADDR_W (IDX_W)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (wr_entry),
        .raddr (idx_reg),
        .rdata (rdata)
    );

    // never-written slots read as the all-zero reset entry
    assign ent = ent_valid_reg ? light_entry_t'(rdata) : '0;

    always_comb begin
        case (cmd.mul_sel)
            SEL_X:   sq_in = {qx_reg[COORD_W-1], qx_reg} - {ent.x[COORD_W-1], ent.x};
            SEL_Y:   sq_in = {qy_reg[COORD_W-1], qy_reg} - {ent.y[COORD_W-1], ent.y};
            SEL_Z:   sq_in = {qz_reg[COORD_W-1], qz_reg} - {ent.z[COORD_W-1], ent.z};
            default: sq_in = {{(DIFF_W-RADIUS_W){1'b0}}, ent.reach};
        endcase
    end

    assign sq_full = sq_in * sq_in;
    assign trial   = {1'b0, res_reg} + {1'b0, bit_reg};
    assign acc_init = (s_view_model && (s_base_light < LEVEL_VIEW)) ?
                      ACC_W'(LEVEL_VIEW) : ACC_W'(s_base_light);

    always_comb begin
        idx_next = idx_reg;
        if (cmd.idx_clr) begin
            idx_next = '0;
        end else if (cmd.idx_inc) begin
            idx_next = idx_reg + IDX_W'(1);
        end

        valid_next = valid_reg;
        if (ram_we) begin
            valid_next[waddr] = 1'b1;
        end

        d2_next = d2_reg;
        if (cmd.d2_clr) begin
            d2_next = '0;
        end else if (cmd.d2_add) begin
            d2_next = d2_reg + DIST_W'(prod_reg);
        end

        rem_next = rem_reg;
        res_next = res_reg;
        bit_next = bit_reg;
        if (cmd.sq_start) begin
            rem_next = d2_reg[ROOT_W-1:0];
            res_next = '0;
            bit_next = ROOT_BIT_INIT;
        end else if (cmd.sq_step) begin
            if ({1'b0, rem_reg} >= trial) begin
                rem_next = rem_reg - trial[ROOT_W-1:0];
                res_next = (res_reg >> 1) + bit_reg;
            end else begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
        end

        acc_next = acc_reg;
        if (cmd.capture) begin
            acc_next = acc_init;
        end else if (cmd.acc_add) begin
            acc_next = acc_reg + ACC_W'(ent.reach) - ACC_W'(res_reg[RADIUS_W-1:0]);
        end

        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_comb begin
        if (fb_reg) begin
            amb_calc   = LEVEL_FULL;
            shade_calc = LEVEL_FULL;
        end else begin
            amb_calc = (acc_reg > ACC_W'(AMBIENT_MAX)) ? AMBIENT_MAX : acc_reg[LEVEL_W-1:0];
            if (acc_reg > ACC_W'(LEVEL_FULL)) begin
                shade_calc = LEVEL_FULL;
            end else if (acc_reg < ACC_W'(SHADE_MIN)) begin
                shade_calc = SHADE_MIN;
            end else begin
                shade_calc = acc_reg[LEVEL_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
            idx_reg     <= '0;
        end else begin
            valid_reg   <= valid_next;
            m_valid_reg <= m_valid_next;
            idx_reg     <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        ent_valid_reg <= valid_reg[idx_reg];
        if (cmd.capture) begin
            qx_reg  <= s_coord_x;
            qy_reg  <= s_coord_y;
            qz_reg  <= s_coord_z;
            now_reg <= s_now_time;
            fb_reg  <= s_full_bright;
        end
        if (cmd.prod_load) begin
            prod_reg <= sq_full[PROD_W-1:0];
        end
        if (cmd.out_load) begin
            amb_reg   <= amb_calc;
            shade_reg <= shade_calc;
        end
        acc_reg <= acc_next;
        d2_reg  <= d2_next;
        rem_reg <= rem_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    // prod_reg holds radius squared, d2_reg the distance squared
    assign sts.in_query = (s_req_type == REQ_QUERY);
    assign sts.in_full  = s_full_bright;
    assign sts.hit      = (ent.expiry >= now_reg) && (d2_reg <= DIST_W'(prod_reg));
    assign sts.sq_last  = bit_reg[0];
    assign sts.idx_last = (idx_reg == IDX_W'(LIGHT_COUNT - 1));
    assign sts.out_free = !m_valid_reg || m_ready;

    assign m_valid         = m_valid_reg;
    assign m_ambient_level = amb_reg;
    assign m_shade_level   = shade_reg;

endmodule

>>> hdl/plac_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// plac_ctrl
// Sequencer: takes items, walks the light table one entry at a time and
// hands the finished levels to the output register.
// ============================================================================
module plac_ctrl
    import plac_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output plac_cmd_t cmd,
    input  plac_sts_t sts
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FETCH = 4'd1;
    localparam logic [3:0] S_MX    = 4'd2;
    localparam logic [3:0] S_MY    = 4'd3;
    localparam logic [3:0] S_MZ    = 4'd4;
    localparam logic [3:0] S_MR    = 4'd5;
    localparam logic [3:0] S_CMP   = 4'd6;
    localparam logic [3:0] S_SQRT  = 4'd7;
    localparam logic [3:0] S_ACC   = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    logic [3:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_sel = SEL_X;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (sts.in_query) begin
                        cmd.capture = 1'b1;
                        cmd.idx_clr = 1'b1;
                        state_next  = sts.in_full ? S_DONE : S_FETCH;
                    end else begin
                        cmd.wr_en = 1'b1;
                    end
                end
            end
            S_FETCH: begin
                state_next = S_MX;
            end
            S_MX: begin
                cmd.mul_sel   = SEL_X;
                cmd.prod_load = 1'b1;
                cmd.d2_clr    = 1'b1;
                state_next    = S_MY;
            end
            S_MY: begin
                cmd.mul_sel   = SEL_Y;
                cmd.prod_load = 1'b1;
                cmd.d2_add    = 1'b1;
                state_next    = S_MZ;
            end
            S_MZ: begin
                cmd.mul_sel   = SEL_Z;
                cmd.prod_load = 1'b1;
                cmd.d2_add    = 1'b1;
                state_next    = S_MR;
            end
            S_MR: begin
                cmd.mul_sel   = SEL_R;
                cmd.prod_load = 1'b1;
                cmd.d2_add    = 1'b1;
                state_next    = S_CMP;
            end
            S_CMP: begin
                cmd.sq_start = 1'b1;
                if (sts.hit) begin
                    state_next = S_SQRT;
                end else if (sts.idx_last) begin
                    state_next = S_DONE;
                end else begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_FETCH;
                end
            end
            S_SQRT: begin
                cmd.sq_step = 1'b1;
                if (sts.sq_last) begin
                    state_next = S_ACC;
                end
            end
            S_ACC: begin
                cmd.acc_add = 1'b1;
                if (sts.idx_last) begin
                    state_next = S_DONE;
                end else begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_FETCH;
                end
            end
            S_DONE: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hdl/point_light_accumulator_unit.sv
`timescale 1ns / 1ps
// Sequence: a light write is taken in the idle state. A query walks each table entry
//   through fetch, x, y, z and radius squaring and compare, plus a 12-step root and an
//   accumulate for each live light in reach; a full bright query skips the walk.
// Throughput: one item at a time, set by the table walk. A result waits in the output
//   register while the next item is taken; a later query stalls until it is taken.
// Reset: synchronous, active low; all table slots read as zero after reset.
// ============================================================================
// point_light_accumulator_unit
// Point light table with query of ambient and shade levels at a point.
// ============================================================================
module point_light_accumulator_unit
    import plac_pkg::*;
#(
    parameter int LIGHT_COUNT = LIGHT_COUNT_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_req_type,
    input  logic [SLOT_W-1:0]         s_light_slot,
    input  logic signed [COORD_W-1:0] s_coord_x,
    input  logic signed [COORD_W-1:0] s_coord_y,
    input  logic signed [COORD_W-1:0] s_coord_z,
    input  logic [RADIUS_W-1:0]       s_light_radius,
    input  logic [TIME_W-1:0]         s_expire_time,
    input  logic [TIME_W-1:0]         s_now_time,
    input  logic [LEVEL_W-1:0]        s_base_light,
    input  logic                      s_full_bright,
    input  logic                      s_view_model,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [LEVEL_W-1:0]        m_ambient_level,
    output logic [LEVEL_W-1:0]        m_shade_level
);

    plac_cmd_t cmd;
    plac_sts_t sts;

    plac_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    plac_datapath #(
        .LIGHT_COUNT (LIGHT_COUNT)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .s_req_type      (s_req_type),
        .s_light_slot    (s_light_slot),
        .s_coord_x       (s_coord_x),
        .s_coord_y       (s_coord_y),
        .s_coord_z       (s_coord_z),
        .s_light_radius  (s_light_radius),
        .s_expire_time   (s_expire_time),
        .s_now_time      (s_now_time),
        .s_base_light    (s_base_light),
        .s_full_bright   (s_full_bright),
        .s_view_model    (s_view_model),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_ambient_level (m_ambient_level),
        .m_shade_level   (m_shade_level)
    );

endmodule

>>> tb/tb_point_light_accumulator_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_point_light_accumulator_unit
// Self-checking bench for the point light accumulator. A short table of
// directed items covers reset contents, full bright, view model, expiry,
// lights exactly at their radius and the coordinate extremes. Clustered
// random scenes follow so that most queries fall inside several lights.
// A local light table predicts ambient and shade unless a row gives them;
// results are checked in order, mostly under random idling on both channels.
// ============================================================================
module tb_point_light_accumulator_unit;
    import plac_pkg::*;

    localparam int LIGHT_COUNT   = LIGHT_COUNT_DEF;
    localparam int RAND_ITEMS    = 1150;
    localparam int DIR_ITEMS     = 23;
    localparam int SETTLE_CYCLES = 19 * LIGHT_COUNT + 2 + 40;

    typedef struct packed {
        logic                       req;
        logic [SLOT_W-1:0]          slot;
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic signed [COORD_W-1:0]  z;
        logic [RADIUS_W-1:0]        radius;
        logic [TIME_W-1:0]          expire;
        logic [TIME_W-1:0]          now;
        logic [LEVEL_W-1:0]         base;
        logic                       full;
        logic                       view;
        logic                       given;
        logic [LEVEL_W-1:0]         amb;
        logic [LEVEL_W-1:0]         shd;
    } stim_row_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] amb;
        logic [LEVEL_W-1:0] shd;
    } level_pair_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic                      s_req_type = REQ_WRITE;
    logic [SLOT_W-1:0]         s_light_slot = '0;
    logic signed [COORD_W-1:0] s_coord_x = '0;
    logic signed [COORD_W-1:0] s_coord_y = '0;
    logic signed [COORD_W-1:0] s_coord_z = '0;
    logic [RADIUS_W-1:0]       s_light_radius = '0;
    logic [TIME_W-1:0]         s_expire_time = '0;
    logic [TIME_W-1:0]         s_now_time = '0;
    logic [LEVEL_W-1:0]        s_base_light = '0;
    logic                      s_full_bright = 1'b0;
    logic                      s_view_model = 1'b0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic [LEVEL_W-1:0]        m_ambient_level;
    logic [LEVEL_W-1:0]        m_shade_level;

    // local copy of the light table
    logic signed [COORD_W-1:0] lt_x      [LIGHT_COUNT] = '{default: '0};
    logic signed [COORD_W-1:0] lt_y      [LIGHT_COUNT] = '{default: '0};
    logic signed [COORD_W-1:0] lt_z      [LIGHT_COUNT] = '{default: '0};
    logic [RADIUS_W-1:0]       lt_reach  [LIGHT_COUNT] = '{default: '0};
    logic [TIME_W-1:0]         lt_expiry [LIGHT_COUNT] = '{default: '0};

    level_pair_t level_queue [$];
    int          mismatches = 0;
    bit          idle_on = 1'b0;
    int          stall_left = 0;

    logic signed [COORD_W-1:0] scene_cx = '0;
    logic signed [COORD_W-1:0] scene_cy = '0;
    logic signed [COORD_W-1:0] scene_cz = '0;
    logic [TIME_W-1:0]         scene_now = '0;

    stim_row_t dir_rows [DIR_ITEMS] = '{
        '{REQ_QUERY, 5'd17, 16'sd0, 16'sd0, 16'sd0, 12'hFFF, 32'hFFFF_FFFF, 32'd0,
          8'd0, 1'b0, 1'b0, 1'b1, 8'd0, SHADE_MIN},
        '{REQ_QUERY, 5'd31, 16'sd1234, -16'sd77, 16'sd9, 12'd0, 32'd0, 32'd5,
          8'd200, 1'b0, 1'b0, 1'b1, AMBIENT_MAX, 8'd200},
        '{REQ_QUERY, 5'd0, 16'sh8000, 16'sh7FFF, 16'sh8000, 12'hABC, 32'h5555_AAAA, 32'd9,
          8'd0, 1'b1, 1'b0, 1'b1, LEVEL_FULL, LEVEL_FULL},
        '{REQ_QUERY, 5'd5, 16'sd3, 16'sd3, 16'sd3, 12'd7, 32'd3, 32'd1,
          8'd10, 1'b0, 1'b1, 1'b1, LEVEL_VIEW, LEVEL_VIEW},
        '{REQ_QUERY, 5'd9, -16'sd1, -16'sd1, -16'sd1, 12'd1, 32'd1, 32'd2,
          8'd255, 1'b0, 1'b1, 1'b1, AMBIENT_MAX, LEVEL_FULL},
        '{REQ_QUERY, 5'd2, 16'sd10, 16'sd20, 16'sd30, 12'd5, 32'd0, 32'd7,
          8'd31, 1'b0, 1'b0, 1'b1, 8'd31, SHADE_MIN},
        '{REQ_WRITE, 5'd0, 16'sd0, 16'sd0, 16'sd0, 12'd100, 32'd1000, 32'hFFFF_FFFF,
          8'd255, 1'b1, 1'b1, 1'b0, 8'd0, 8'd0},
        '{REQ_QUERY, 5'd0, 16'sd30, 16'sd40, 16'sd0, 12'd0, 32'd0, 32'd1000,
          8'd0, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0},
        '{REQ_QUERY, 5'd0, 16'sd60, 16'sd80, 16'sd0, 12'd0, 32'd0, 32'd0,
          8'd0, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0},
        '{REQ_QUERY, 5'd0, 16'sd30, 16'sd40, 16'sd0, 12'd0, 32'd0, 32'd1001,
          8'd0, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0},
        '{REQ_WRITE, 5'd31, 16'sh8000, 16'sh8000, 16'sh8000, 12'hFFF, 32'hFFFF_FFFF, 32'd0,
          8'd0, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0},
        '{REQ_WRITE, 5'd1, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 12'hFFF, 32'hFFFF_FFFF, 32'd0,
          8'd0, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0},
        '{REQ_QUERY, 5'd31, 16'sh8000, 16'sh8000, 16'sh8000, 12'hFFF, 32'hFFFF_FFFF,
          32'hFFFF_FFFF, 8'd0, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0},
        '{REQ_QUERY, 5'd1, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 12'd0, 32'd0, 32'hFFFF_FFFF,
          8'd255, 1'b0, 1'b1, 1'b0, 8'd0, 8'd0},
        '{REQ_QUERY, 5'd12, 16'sh7FFF, 16'sh8000, 16'sd0, 12'd3, 32'd8, 32'd0,
          8'd100, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0},
        '{REQ_WRITE, 5'd2, 16'sd100, -16'sd100, 16'sd50, 12'd1, 32'd50, 32'hFFFF_FFFF,
          8'd77, 1'b1, 1'b0, 1'b0, 8'd0, 8'd0},
        '{REQ_QUERY, 5'd2, 16'sd100, -16'sd100, 16'sd50, 12'd9, 32'd4, 32'd50,
          8'd31, 1'b0, 1'b1, 1'b0, 8'd0, 8'd0},
        '{REQ_QUERY, 5'd2, 16'sd101, -16'sd100, 16'sd50, 12'd9, 32'd4, 32'd50,
          8'd31, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0},
        '{REQ_WRITE, 5'd3, 16'sd5, 16'sd5, 16'sd5, 12'd0, 32'hFFFF_FFFF, 32'd0,
          8'd0, 1'b0, 1'b1, 1'b0, 8'd0, 8'd0},
        '{REQ_QUERY, 5'd3, 16'sd5, 16'sd5, 16'sd5, 12'd0, 32'd0, 32'd2,
          8'd40, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0},
        '{REQ_WRITE, 5'd4, 16'sd0, 16'sd0, 16'sd0, 12'hFFF, 32'hFFFF_FFFF, 32'd0,
          8'd0, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0},
        '{REQ_QUERY, 5'd4, 16'sd0, 16'sd0, 16'sd0, 12'd0, 32'd0, 32'd0,
          8'd255, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0},
        '{REQ_QUERY, 5'd0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 12'hFFF, 32'd0, 32'd0,
          8'd255, 1'b1, 1'b1, 1'b1, LEVEL_FULL, LEVEL_FULL}
    };

    point_light_accumulator_unit dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_light_slot    (s_light_slot),
        .s_coord_x       (s_coord_x),
        .s_coord_y       (s_coord_y),
        .s_coord_z       (s_coord_z),
        .s_light_radius  (s_light_radius),
        .s_expire_time   (s_expire_time),
        .s_now_time      (s_now_time),
        .s_base_light    (s_base_light),
        .s_full_bright   (s_full_bright),
        .s_view_model    (s_view_model),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_ambient_level (m_ambient_level),
        .m_shade_level   (m_shade_level)
    );

    always #2 aclk = ~aclk;

    task automatic flag_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    function automatic int floor_root(input longint v);
        int     root;
        longint trial;
        root = 0;
        for (int k = 12; k >= 0; k--) begin
            trial = longint'(root | (1 << k));
            if (trial * trial <= v) begin
                root = root | (1 << k);
            end
        end
        return root;
    endfunction

    // updates the light table on a write, queues the expected levels on a query
    task automatic account_item(input stim_row_t it);
        level_pair_t want;
        longint      dx, dy, dz, d2, r2;
        int          amb, shd;
        if (it.req == REQ_WRITE) begin
            lt_x[it.slot]      = it.x;
            lt_y[it.slot]      = it.y;
            lt_z[it.slot]      = it.z;
            lt_reach[it.slot]  = it.radius;
            lt_expiry[it.slot] = it.expire;
        end else if (it.given) begin
            want.amb = it.amb;
            want.shd = it.shd;
            level_queue.push_back(want);
        end else begin
            if (it.full) begin
                amb = LEVEL_FULL;
                shd = LEVEL_FULL;
            end else begin
                amb = it.base;
                if (it.view && amb < LEVEL_VIEW) begin
                    amb = LEVEL_VIEW;
                end
                shd = amb;
                for (int i = 0; i < LIGHT_COUNT; i++) begin
                    if (lt_expiry[i] >= it.now) begin
                        dx = longint'(it.x) - longint'(lt_x[i]);
                        dy = longint'(it.y) - longint'(lt_y[i]);
                        dz = longint'(it.z) - longint'(lt_z[i]);
                        d2 = dx * dx + dy * dy + dz * dz;
                        r2 = longint'(lt_reach[i]) * longint'(lt_reach[i]);
                        if (d2 <= r2) begin
                            amb += int'(lt_reach[i]) - floor_root(d2);
                            shd += int'(lt_reach[i]) - floor_root(d2);
                        end
                    end
                end
                if (shd > LEVEL_FULL) begin
                    shd = LEVEL_FULL;
                end else if (shd < SHADE_MIN) begin
                    shd = SHADE_MIN;
                end
                if (amb > AMBIENT_MAX) begin
                    amb = AMBIENT_MAX;
                end
            end
            want.amb = LEVEL_W'(amb);
            want.shd = LEVEL_W'(shd);
            level_queue.push_back(want);
        end
    endtask

    function automatic logic signed [COORD_W-1:0] scatter(
        input logic signed [COORD_W-1:0] c,
        input int                        span
    );
        return COORD_W'(c + $urandom_range(0, 2 * span) - span);
    endfunction

    // mostly lights and queries around the current scene, the rest noise
    function automatic stim_row_t random_item();
        stim_row_t it;
        int        pick;
        it.req    = 1'($urandom);
        it.slot   = SLOT_W'($urandom);
        it.x      = COORD_W'($urandom);
        it.y      = COORD_W'($urandom);
        it.z      = COORD_W'($urandom);
        it.radius = RADIUS_W'($urandom);
        it.expire = $urandom;
        it.now    = $urandom;
        it.base   = LEVEL_W'($urandom);
        it.full   = 1'($urandom);
        it.view   = 1'($urandom);
        it.given  = 1'b0;
        it.amb    = '0;
        it.shd    = '0;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            it.req = REQ_WRITE;
            it.x   = scatter(scene_cx, 200);
            it.y   = scatter(scene_cy, 200);
            it.z   = scatter(scene_cz, 200);
            case ($urandom_range(0, 5))
                0, 1:    it.radius = RADIUS_W'($urandom_range(0, 40));
                2, 3, 4: it.radius = RADIUS_W'($urandom_range(1, 400));
                default: it.radius = RADIUS_W'($urandom);
            endcase
            it.expire = scene_now + $urandom_range(0, 3000) - 1000;
        end else if (pick < 88) begin
            it.req  = REQ_QUERY;
            it.x    = scatter(scene_cx, 200);
            it.y    = scatter(scene_cy, 200);
            it.z    = scatter(scene_cz, 200);
            it.now  = scene_now;
            it.full = ($urandom_range(0, 15) == 0);
            if ($urandom_range(0, 1) == 1) begin
                it.base = LEVEL_W'($urandom_range(0, 40));
            end
            scene_now = scene_now + $urandom_range(0, 40);
        end
        return it;
    endfunction

    task automatic send_item(input stim_row_t it);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_req_type     <= it.req;
        s_light_slot   <= it.slot;
        s_coord_x      <= it.x;
        s_coord_y      <= it.y;
        s_coord_z      <= it.z;
        s_light_radius <= it.radius;
        s_expire_time  <= it.expire;
        s_now_time     <= it.now;
        s_base_light   <= it.base;
        s_full_bright  <= it.full;
        s_view_model   <= it.view;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        account_item(it);
        @(negedge aclk);
    endtask

    task automatic hold_until_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (level_queue.size() != 0);
    endtask

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 2);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : result_check
        level_pair_t want;
        if (aresetn && m_valid && m_ready) begin
            if (level_queue.size() == 0) begin
                flag_mismatch($sformatf("unexpected result amb=%0d shd=%0d",
                                        m_ambient_level, m_shade_level));
            end else begin
                want = level_queue.pop_front();
                if (m_ambient_level !== want.amb) begin
                    flag_mismatch($sformatf("ambient got %0d want %0d",
                                            m_ambient_level, want.amb));
                end
                if (m_shade_level !== want.shd) begin
                    flag_mismatch($sformatf("shade got %0d want %0d",
                                            m_shade_level, want.shd));
                end
            end
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        idle_on = 1'b1;
        for (int i = 0; i < DIR_ITEMS; i++) begin
            send_item(dir_rows[i]);
        end
        hold_until_drained();
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n % 60 == 0) begin
                scene_cx  = COORD_W'($urandom);
                scene_cy  = COORD_W'($urandom);
                scene_cz  = COORD_W'($urandom);
                scene_now = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 100) : $urandom;
            end
            if (n == RAND_ITEMS / 2) begin
                hold_until_drained();
            end
            idle_on = !((n >= 400 && n < 520) || n >= RAND_ITEMS - 150);
            send_item(random_item());
        end
        s_valid <= 1'b0;
        while (level_queue.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #15_000_000;
        $display("timeout, %0d results outstanding", level_queue.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
